// File: design/otm_pkg.sv
// Shared constants and codes of the overcurrent trip monitor.
// Used by otm_mult and by the top level; depends on nothing.
package otm_pkg;

  // Default parameter values.
  localparam int unsigned ADC_BITS_DEF      = 10;
  localparam int unsigned CAL_SAMPLES_DEF   = 100;
  localparam int unsigned FRACTION_BITS_DEF = 16;

  // Fixed field widths.
  localparam int unsigned ALPHA_W   = 16;
  localparam int unsigned LIMIT_W   = 10;
  localparam int unsigned PERIOD_W  = 16;
  localparam int unsigned FUNC_W    = 2;
  localparam int unsigned CFG_IDX_W = 2;
  localparam int unsigned CFG_DATA_W = 16;

  // Load fraction is Q0.16, with one extra bit to carry exactly 1.0.
  localparam int unsigned LOAD_FRAC = 16;
  localparam int unsigned LOAD_W    = LOAD_FRAC + 1;
  localparam logic [LOAD_W-1:0] LOAD_ONE = LOAD_W'(1) << LOAD_FRAC;

  // Register reset values.
  localparam logic [ALPHA_W-1:0]  ALPHA_RST  = ALPHA_W'(655);
  localparam logic [LIMIT_W-1:0]  LIMIT_RST  = LIMIT_W'(300);
  localparam logic [PERIOD_W-1:0] PERIOD_RST = PERIOD_W'(1);

  typedef enum logic [FUNC_W-1:0] {
    FUNC_TICK       = 2'd0,
    FUNC_CAL_SAMPLE = 2'd1,
    FUNC_CAL_START  = 2'd2,
    FUNC_CLEAR      = 2'd3
  } otm_func_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_ALPHA     = 2'd0,
    CFG_LIMIT     = 2'd1,
    CFG_PERIOD    = 2'd2,
    CFG_SYMMETRIC = 2'd3
  } otm_cfg_e;

endpackage

// File: design/overcurrent_trip_monitor_unit.sv
// Overcurrent trip monitor for a track driver, top level.
// Depends on otm_pkg, otm_mult and otm_div.
//
// Each input transfer carries a function code, a converter sample and the
// driver fault level, and produces exactly one result transfer. The unit
// handles one item at a time: the input is ready only while no item is in
// progress, but a finished result waits in its own output register, so the
// next item may be taken while that result is still pending. Two bit-serial
// units do the arithmetic: the smoothing update uses a shift-and-add unit at
// one weight bit per cycle, and the load fraction a restoring divider at one
// quotient bit per cycle. A tick that updates the smoothed value first runs
// the multiplier and then the trip check; the final calibration sample
// first runs the divider over ADC_BITS + FRACTION_BITS bits to form the
// average. Every item then forms the load fraction, but when the load ratio
// saturates (the smoothed value is at or above the limit, or the limit is
// zero) the divider is skipped.
// Configuration writes are always accepted and must only be issued while
// the unit is idle.
module overcurrent_trip_monitor_unit #(
  parameter int unsigned ADC_BITS            = otm_pkg::ADC_BITS_DEF,
  parameter int unsigned CALIBRATION_SAMPLES = otm_pkg::CAL_SAMPLES_DEF,
  parameter int unsigned FRACTION_BITS       = otm_pkg::FRACTION_BITS_DEF
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  // Configuration write channel
  input  logic                                cfg_valid_i,
  output logic                                cfg_ready_o,
  input  logic [otm_pkg::CFG_IDX_W-1:0]       cfg_index_i,
  input  logic [otm_pkg::CFG_DATA_W-1:0]      cfg_data_i,
  // Input item channel
  input  logic                                in_valid_i,
  output logic                                in_ready_o,
  input  logic [otm_pkg::FUNC_W-1:0]          func_i,
  input  logic [ADC_BITS-1:0]                 adc_sample_i,
  input  logic                                fault_low_i,
  // Result channel
  output logic                                out_valid_o,
  input  logic                                out_ready_i,
  output logic                                shut_off_o,
  output logic                                error_latched_o,
  output logic                                new_error_o,
  output logic [ADC_BITS+FRACTION_BITS-1:0]   current_level_o,
  output logic [otm_pkg::LOAD_W-1:0]          load_fraction_o,
  output logic [ADC_BITS+FRACTION_BITS-1:0]   reference_level_o,
  output logic                                calibration_done_o
);
  import otm_pkg::*;

  localparam int unsigned LEVEL_BITS = ADC_BITS + FRACTION_BITS;
  localparam int unsigned LIM_BITS   = LIMIT_W + FRACTION_BITS;
  localparam int unsigned DIV_BITS   = (LEVEL_BITS > LIM_BITS) ? LEVEL_BITS : LIM_BITS;
  localparam int unsigned ALIGN      = DIV_BITS - LEVEL_BITS;
  localparam int unsigned STEP_W     = $clog2(DIV_BITS + 1);
  localparam int unsigned CNT_W      = $clog2(CALIBRATION_SAMPLES + 1);
  localparam int unsigned SUM_W      = ADC_BITS + CNT_W;

  typedef enum logic [2:0] {
    ST_IDLE, ST_MULT, ST_TRIP, ST_CAL, ST_LOAD, ST_LDIV, ST_OUT
  } state_e;

  // Configuration registers.
  logic [ALPHA_W-1:0]  alpha_q;
  logic [LIMIT_W-1:0]  limit_q;
  logic [PERIOD_W-1:0] period_q;
  logic                symmetric_q;

  // Monitor state.
  state_e                state_q;
  logic [LEVEL_BITS-1:0] cur_q, ref_q, diff_q;
  logic                  err_q, ref_valid_q;
  logic [PERIOD_W-1:0]   elapsed_q;
  logic [SUM_W-1:0]      sum_q;
  logic [CNT_W-1:0]      count_q;
  logic                  fault_q, trip_q, fresh_q;
  logic [LOAD_W-1:0]     load_q;
  logic                  mult_start_q, div_start_q, div_cal_q;

  // Result register.
  logic                  out_valid_q, shut_off_q, err_out_q, new_err_q, cal_done_q;
  logic [LEVEL_BITS-1:0] cur_out_q, ref_out_q;
  logic [LOAD_W-1:0]     load_out_q;

  // Datapath helpers.
  otm_func_e             func;
  logic [LEVEL_BITS-1:0] sample_ext, diff;
  logic [PERIOD_W-1:0]   elapsed_inc;
  logic [SUM_W-1:0]      sum_inc;
  logic [CNT_W-1:0]      count_inc;
  logic [DIV_BITS-1:0]   cur_ext, lim_ext;
  logic [DIV_BITS-1:0]   div_rem, div_dvd, div_dsr, div_quot;
  logic [STEP_W-1:0]     div_steps;
  logic                  mult_done, div_done;
  logic [LEVEL_BITS-1:0] mult_result;

  assign func        = otm_func_e'(func_i);
  assign sample_ext  = {adc_sample_i, FRACTION_BITS'(0)};
  assign diff        = (sample_ext >= ref_q) ? sample_ext - ref_q : ref_q - sample_ext;
  assign elapsed_inc = (elapsed_q == '1) ? elapsed_q : elapsed_q + PERIOD_W'(1);
  assign sum_inc     = sum_q + SUM_W'(adc_sample_i);
  assign count_inc   = count_q + CNT_W'(1);
  assign cur_ext     = DIV_BITS'(cur_q);
  assign lim_ext     = DIV_BITS'({limit_q, FRACTION_BITS'(0)});

  // Divider operands: the calibration average uses the running sum, whose
  // upper part is already below the sample count; the load uses the
  // smoothed level, already below the limit.
  always_comb begin
    if (div_cal_q) begin
      div_rem   = DIV_BITS'(sum_q[SUM_W-1:ADC_BITS]);
      div_dvd   = DIV_BITS'({sum_q[ADC_BITS-1:0], FRACTION_BITS'(0)}) << ALIGN;
      div_dsr   = DIV_BITS'(CALIBRATION_SAMPLES);
      div_steps = STEP_W'(LEVEL_BITS);
    end else begin
      div_rem   = cur_ext;
      div_dvd   = '0;
      div_dsr   = lim_ext;
      div_steps = STEP_W'(LOAD_FRAC);
    end
  end

  otm_mult #(
    .LEVEL_BITS(LEVEL_BITS)
  ) u_mult (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start_i  (mult_start_q),
    .diff_i   (diff_q),
    .level_i  (cur_q),
    .alpha_i  (alpha_q),
    .done_o   (mult_done),
    .result_o (mult_result)
  );

  otm_div #(
    .WIDTH(DIV_BITS)
  ) u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start_q),
    .steps_i    (div_steps),
    .rem_i      (div_rem),
    .dividend_i (div_dvd),
    .divisor_i  (div_dsr),
    .done_o     (div_done),
    .quotient_o (div_quot)
  );

  // Configuration writes complete in the cycle they are offered.
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      alpha_q     <= ALPHA_RST;
      limit_q     <= LIMIT_RST;
      period_q    <= PERIOD_RST;
      symmetric_q <= 1'b0;
    end else if (cfg_valid_i) begin
      unique case (otm_cfg_e'(cfg_index_i))
        CFG_ALPHA:     alpha_q     <= cfg_data_i[ALPHA_W-1:0];
        CFG_LIMIT:     limit_q     <= cfg_data_i[LIMIT_W-1:0];
        CFG_PERIOD:    period_q    <= cfg_data_i[PERIOD_W-1:0];
        CFG_SYMMETRIC: symmetric_q <= cfg_data_i[0];
        default:       alpha_q     <= alpha_q;
      endcase
    end
  end

  // Sequencer: state, monitor registers and result register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= ST_IDLE;
      cur_q        <= '0;
      ref_q        <= '0;
      diff_q       <= '0;
      err_q        <= 1'b0;
      ref_valid_q  <= 1'b1;
      elapsed_q    <= '0;
      sum_q        <= '0;
      count_q      <= '0;
      fault_q      <= 1'b0;
      trip_q       <= 1'b0;
      fresh_q      <= 1'b0;
      load_q       <= '0;
      mult_start_q <= 1'b0;
      div_start_q  <= 1'b0;
      div_cal_q    <= 1'b0;
      out_valid_q  <= 1'b0;
      shut_off_q   <= 1'b0;
      err_out_q    <= 1'b0;
      new_err_q    <= 1'b0;
      cal_done_q   <= 1'b0;
      cur_out_q    <= '0;
      ref_out_q    <= '0;
      load_out_q   <= '0;
    end else begin
      mult_start_q <= 1'b0;
      div_start_q  <= 1'b0;
      if (out_valid_q && out_ready_i) begin
        out_valid_q <= 1'b0;
      end
      unique case (state_q)
        ST_IDLE: begin
          if (in_valid_i) begin
            fault_q <= fault_low_i;
            trip_q  <= 1'b0;
            fresh_q <= 1'b0;
            state_q <= ST_LOAD;
            unique case (func)
              FUNC_TICK: begin
                if (elapsed_inc >= period_q) begin
                  elapsed_q    <= '0;
                  diff_q       <= diff;
                  mult_start_q <= 1'b1;
                  state_q      <= ST_MULT;
                end else begin
                  elapsed_q <= elapsed_inc;
                end
              end
              FUNC_CAL_SAMPLE: begin
                if (!ref_valid_q) begin
                  sum_q   <= sum_inc;
                  count_q <= count_inc;
                  if (count_inc >= CNT_W'(CALIBRATION_SAMPLES)) begin
                    div_cal_q   <= 1'b1;
                    div_start_q <= 1'b1;
                    state_q     <= ST_CAL;
                  end
                end
              end
              FUNC_CAL_START: begin
                sum_q   <= '0;
                count_q <= '0;
                if (symmetric_q) begin
                  ref_valid_q <= 1'b0;
                end else begin
                  ref_q       <= '0;
                  ref_valid_q <= 1'b1;
                end
              end
              FUNC_CLEAR: begin
                err_q <= 1'b0;
              end
              default: begin
                err_q <= err_q;
              end
            endcase
          end
        end
        ST_MULT: begin
          if (mult_done) begin
            cur_q   <= mult_result;
            state_q <= ST_TRIP;
          end
        end
        ST_TRIP: begin
          // The error is reported only on the update that first latches it.
          if ((cur_ext > lim_ext) || fault_q) begin
            trip_q <= 1'b1;
            if (!err_q) begin
              err_q   <= 1'b1;
              fresh_q <= 1'b1;
            end
          end
          state_q <= ST_LOAD;
        end
        ST_CAL: begin
          if (div_done) begin
            ref_q       <= div_quot[LEVEL_BITS-1:0];
            ref_valid_q <= 1'b1;
            sum_q       <= '0;
            count_q     <= '0;
            state_q     <= ST_LOAD;
          end
        end
        ST_LOAD: begin
          if ((limit_q == '0) || (cur_ext >= lim_ext)) begin
            load_q  <= LOAD_ONE;
            state_q <= ST_OUT;
          end else begin
            div_cal_q   <= 1'b0;
            div_start_q <= 1'b1;
            state_q     <= ST_LDIV;
          end
        end
        ST_LDIV: begin
          if (div_done) begin
            load_q  <= {1'b0, div_quot[LOAD_FRAC-1:0]};
            state_q <= ST_OUT;
          end
        end
        ST_OUT: begin
          if (!out_valid_q || out_ready_i) begin
            out_valid_q <= 1'b1;
            shut_off_q  <= trip_q;
            err_out_q   <= err_q;
            new_err_q   <= fresh_q;
            cur_out_q   <= cur_q;
            load_out_q  <= load_q;
            ref_out_q   <= ref_q;
            cal_done_q  <= ref_valid_q;
            state_q     <= ST_IDLE;
          end
        end
        default: begin
          state_q <= ST_IDLE;
        end
      endcase
    end
  end

  assign in_ready_o         = (state_q == ST_IDLE);
  assign out_valid_o        = out_valid_q;
  assign shut_off_o         = shut_off_q;
  assign error_latched_o    = err_out_q;
  assign new_error_o        = new_err_q;
  assign current_level_o    = cur_out_q;
  assign load_fraction_o    = load_out_q;
  assign reference_level_o  = ref_out_q;
  assign calibration_done_o = cal_done_q;

  // A fresh error report always comes with a trip and a latched error.
  a_new_error_implies_trip: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && new_error_o |-> shut_off_o && error_latched_o)
    else $error("new error reported without trip");

  // The load fraction never exceeds one.
  a_load_bounded: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> load_fraction_o <= LOAD_ONE)
    else $error("load fraction above one");

  // Between items the calibration count is below the run length.
  a_count_bounded: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_IDLE |-> count_q < CNT_W'(CALIBRATION_SAMPLES))
    else $error("calibration count out of range");

  // The error latches only through a trip on a smoothing update.
  a_error_from_trip: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(err_q) |-> trip_q && fresh_q && $past(state_q) == ST_TRIP)
    else $error("error latched without a trip");

endmodule

// File: design/otm_mult.sv
// Bit-serial weighted sum for the smoothing update:
// (diff * alpha + level * (1.0 - alpha)) >> 16, one weight bit per cycle.
// Depends on otm_pkg.
module otm_mult #(
  parameter int unsigned LEVEL_BITS = otm_pkg::ADC_BITS_DEF + otm_pkg::FRACTION_BITS_DEF
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        start_i,
  input  logic [LEVEL_BITS-1:0]       diff_i,
  input  logic [LEVEL_BITS-1:0]       level_i,
  input  logic [otm_pkg::ALPHA_W-1:0] alpha_i,
  output logic                        done_o,
  output logic [LEVEL_BITS-1:0]       result_o
);
  import otm_pkg::*;

  localparam int unsigned WEIGHT_W = ALPHA_W + 1;
  localparam int unsigned ACC_W    = LEVEL_BITS + ALPHA_W;
  localparam int unsigned CNT_W    = $clog2(WEIGHT_W + 1);
  localparam logic [WEIGHT_W-1:0] WEIGHT_ONE = WEIGHT_W'(1) << ALPHA_W;

  logic                  busy_q, done_q;
  logic [CNT_W-1:0]      cnt_q;
  logic [WEIGHT_W-1:0]   a_q, b_q;
  logic [LEVEL_BITS-1:0] diff_q, level_q;
  logic [ACC_W-1:0]      acc_q;
  logic [LEVEL_BITS:0]   partial;
  logic [ACC_W-1:0]      acc_d;

  // Weights are consumed most significant bit first.
  always_comb begin
    partial = (a_q[WEIGHT_W-1] ? {1'b0, diff_q} : '0)
            + (b_q[WEIGHT_W-1] ? {1'b0, level_q} : '0);
    acc_d   = {acc_q[ACC_W-2:0], 1'b0} + ACC_W'(partial);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= CNT_W'(WEIGHT_W);
      end else if (busy_q) begin
        cnt_q <= cnt_q - CNT_W'(1);
        if (cnt_q == CNT_W'(1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      a_q     <= {1'b0, alpha_i};
      b_q     <= WEIGHT_ONE - {1'b0, alpha_i};
      diff_q  <= diff_i;
      level_q <= level_i;
      acc_q   <= '0;
    end else if (busy_q) begin
      a_q   <= {a_q[WEIGHT_W-2:0], 1'b0};
      b_q   <= {b_q[WEIGHT_W-2:0], 1'b0};
      acc_q <= acc_d;
    end
  end

  assign done_o   = done_q;
  assign result_o = acc_q[ACC_W-1:ALPHA_W];

endmodule

// File: design/otm_div.sv
// Restoring divider producing one quotient bit per cycle, shared by the
// calibration average and the load fraction. No package dependency.
module otm_div #(
  parameter int unsigned WIDTH = 26
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         start_i,
  input  logic [$clog2(WIDTH+1)-1:0]   steps_i,
  input  logic [WIDTH-1:0]             rem_i,
  input  logic [WIDTH-1:0]             dividend_i,
  input  logic [WIDTH-1:0]             divisor_i,
  output logic                         done_o,
  output logic [WIDTH-1:0]             quotient_o
);

  localparam int unsigned STEP_W = $clog2(WIDTH + 1);

  logic              busy_q, done_q;
  logic [STEP_W-1:0] cnt_q;
  logic [WIDTH-1:0]  rem_q, dvd_q, dsr_q, quot_q;
  logic [WIDTH:0]    trial;
  logic              fits;
  logic [WIDTH-1:0]  rem_d;

  // The partial remainder stays below the divisor, so the trial fits WIDTH+1 bits.
  always_comb begin
    trial = {rem_q, dvd_q[WIDTH-1]};
    fits  = trial >= {1'b0, dsr_q};
    rem_d = fits ? WIDTH'(trial - {1'b0, dsr_q}) : trial[WIDTH-1:0];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= steps_i;
      end else if (busy_q) begin
        cnt_q <= cnt_q - STEP_W'(1);
        if (cnt_q == STEP_W'(1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rem_q  <= rem_i;
      dvd_q  <= dividend_i;
      dsr_q  <= divisor_i;
      quot_q <= '0;
    end else if (busy_q) begin
      rem_q  <= rem_d;
      dvd_q  <= {dvd_q[WIDTH-2:0], 1'b0};
      quot_q <= {quot_q[WIDTH-2:0], fits};
    end
  end

  assign done_o     = done_q;
  assign quotient_o = quot_q;

endmodule

// File: tb/sv/otm_tb_pkg.sv
`timescale 1ns / 100ps
// Scoreboard for the overcurrent trip monitor testbench: bit-true predictor and result checks.
// Depends on otm_pkg for widths, register codes and function codes.
package otm_tb_pkg;
  import otm_pkg::*;

  localparam int unsigned ADC_W       = ADC_BITS_DEF;
  localparam int unsigned FRAC_BITS   = FRACTION_BITS_DEF;
  localparam int unsigned LEVEL_W     = ADC_BITS_DEF + FRACTION_BITS_DEF;
  localparam int unsigned CAL_SAMPLES = CAL_SAMPLES_DEF;

  typedef struct {
    logic               shut_off;
    logic               error_latched;
    logic               new_error;
    logic [LEVEL_W-1:0] current_level;
    logic [LOAD_W-1:0]  load_fraction;
    logic [LEVEL_W-1:0] reference_level;
    logic               calibration_done;
  } trip_report_t;

  class trip_monitor_scoreboard;
    // Register copies.
    logic [ALPHA_W-1:0]  alpha;
    logic [LIMIT_W-1:0]  limit;
    logic [PERIOD_W-1:0] period;
    logic                symmetric;
    // Monitor state.
    logic [LEVEL_W-1:0]  smoothed;
    logic [LEVEL_W-1:0]  zero_ref;
    logic                error_flag;
    logic [PERIOD_W-1:0] elapsed;
    logic [16:0]         cal_sum;
    logic [6:0]          cal_count;
    logic                ref_valid;

    trip_report_t expected_reports[$];
    int           mismatches;

    function new();
      alpha      = ALPHA_RST;
      limit      = LIMIT_RST;
      period     = PERIOD_RST;
      symmetric  = 1'b0;
      smoothed   = '0;
      zero_ref   = '0;
      error_flag = 1'b0;
      elapsed    = '0;
      cal_sum    = '0;
      cal_count  = '0;
      ref_valid  = 1'b1;
      mismatches = 0;
    endfunction

    function void write_reg(otm_cfg_e idx, logic [CFG_DATA_W-1:0] data);
      case (idx)
        CFG_ALPHA:     alpha = data;
        CFG_LIMIT:     limit = data[LIMIT_W-1:0];
        CFG_PERIOD:    period = data;
        CFG_SYMMETRIC: symmetric = data[0];
      endcase
    endfunction

    function int pending();
      return expected_reports.size();
    endfunction

    // Advances the monitor by one accepted item and queues the report it must give.
    function void accept_item(otm_func_e f, logic [ADC_W-1:0] sample, logic fault);
      trip_report_t       rep;
      logic [LEVEL_W-1:0] scaled;
      logic [LEVEL_W-1:0] diff;
      logic [LEVEL_W-1:0] limit_q;
      logic [63:0]        acc;
      rep.shut_off  = 1'b0;
      rep.new_error = 1'b0;
      limit_q       = LEVEL_W'(limit) << FRAC_BITS;
      case (f)
        FUNC_TICK: begin
          if (elapsed != '1) elapsed = elapsed + PERIOD_W'(1);
          if (elapsed >= period) begin
            elapsed = '0;
            scaled  = LEVEL_W'(sample) << FRAC_BITS;
            diff    = (scaled >= zero_ref) ? scaled - zero_ref : zero_ref - scaled;
            acc     = 64'(diff) * 64'(alpha) + 64'(smoothed) * (64'd65536 - 64'(alpha));
            smoothed = acc[FRAC_BITS +: LEVEL_W];
            if (smoothed > limit_q || fault) begin
              rep.shut_off = 1'b1;
              if (!error_flag) begin
                error_flag    = 1'b1;
                rep.new_error = 1'b1;
              end
            end
          end
        end
        FUNC_CAL_SAMPLE: begin
          if (!ref_valid) begin
            cal_sum   = cal_sum + 17'(sample);
            cal_count = cal_count + 7'(1);
            if (cal_count >= 7'(CAL_SAMPLES)) begin
              zero_ref  = LEVEL_W'((64'(cal_sum) << FRAC_BITS) / 64'(CAL_SAMPLES));
              ref_valid = 1'b1;
              cal_sum   = '0;
              cal_count = '0;
            end
          end
        end
        FUNC_CAL_START: begin
          cal_sum   = '0;
          cal_count = '0;
          if (symmetric) begin
            ref_valid = 1'b0;
          end else begin
            zero_ref  = '0;
            ref_valid = 1'b1;
          end
        end
        FUNC_CLEAR: error_flag = 1'b0;
      endcase
      // A zero limit saturates the load just like an overload does.
      if (limit_q == '0 || smoothed >= limit_q) begin
        rep.load_fraction = LOAD_ONE;
      end else begin
        rep.load_fraction = LOAD_W'((64'(smoothed) << LOAD_FRAC) / 64'(limit_q));
      end
      rep.error_latched    = error_flag;
      rep.current_level    = smoothed;
      rep.reference_level  = zero_ref;
      rep.calibration_done = ref_valid;
      expected_reports.push_back(rep);
    endfunction

    function void check_field(string name, logic [LEVEL_W-1:0] want, logic [LEVEL_W-1:0] got);
      if (got !== want) begin
        $error("%s: expected %0d, got %0d", name, want, got);
        mismatches++;
      end
    endfunction

    function void compare_result(trip_report_t got);
      trip_report_t want;
      if (expected_reports.size() == 0) begin
        $error("Result transfer arrived with no expectation pending");
        mismatches++;
        return;
      end
      want = expected_reports.pop_front();
      check_field("shut_off", LEVEL_W'(want.shut_off), LEVEL_W'(got.shut_off));
      check_field("error_latched", LEVEL_W'(want.error_latched),
                  LEVEL_W'(got.error_latched));
      check_field("new_error", LEVEL_W'(want.new_error), LEVEL_W'(got.new_error));
      check_field("current_level", want.current_level, got.current_level);
      check_field("load_fraction", LEVEL_W'(want.load_fraction),
                  LEVEL_W'(got.load_fraction));
      check_field("reference_level", want.reference_level, got.reference_level);
      check_field("calibration_done", LEVEL_W'(want.calibration_done),
                  LEVEL_W'(got.calibration_done));
    endfunction
  endclass

endpackage

// File: tb/sv/overcurrent_trip_monitor_unit_test.sv
`timescale 1ns / 100ps
// Top level of the overcurrent trip monitor testbench: clock, reset, stimulus and checking.
// Depends on otm_pkg, otm_tb_pkg and the overcurrent_trip_monitor_unit RTL.
module overcurrent_trip_monitor_unit_test;
  import otm_pkg::*;
  import otm_tb_pkg::*;

  // A clean run of roughly 1500 items, idling included, stays well below this limit.
  localparam int unsigned CYCLE_LIMIT   = 1000000;
  localparam int unsigned PHASES        = 9;
  localparam int unsigned PHASE_ITEMS   = 130;
  localparam int unsigned SETTLE_CYCLES = 64;

  logic                   clk_i        = 1'b0;
  logic                   rst_ni       = 1'b0;
  logic                   cfg_valid_i  = 1'b0;
  logic                   cfg_ready_o;
  logic [CFG_IDX_W-1:0]   cfg_index_i  = '0;
  logic [CFG_DATA_W-1:0]  cfg_data_i   = '0;
  logic                   in_valid_i   = 1'b0;
  logic                   in_ready_o;
  logic [FUNC_W-1:0]      func_i       = '0;
  logic [ADC_W-1:0]       adc_sample_i = '0;
  logic                   fault_low_i  = 1'b0;
  logic                   out_valid_o;
  logic                   out_ready_i  = 1'b0;
  logic                   shut_off_o;
  logic                   error_latched_o;
  logic                   new_error_o;
  logic [LEVEL_W-1:0]     current_level_o;
  logic [LOAD_W-1:0]      load_fraction_o;
  logic [LEVEL_W-1:0]     reference_level_o;
  logic                   calibration_done_o;

  trip_monitor_scoreboard board;
  trip_report_t           seen;
  bit                     idle_en     = 1'b1;
  int                     items_sent  = 0;
  int                     stall_left  = 0;
  int unsigned            cycle_count = 0;

  overcurrent_trip_monitor_unit dut (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .cfg_valid_i        (cfg_valid_i),
    .cfg_ready_o        (cfg_ready_o),
    .cfg_index_i        (cfg_index_i),
    .cfg_data_i         (cfg_data_i),
    .in_valid_i         (in_valid_i),
    .in_ready_o         (in_ready_o),
    .func_i             (func_i),
    .adc_sample_i       (adc_sample_i),
    .fault_low_i        (fault_low_i),
    .out_valid_o        (out_valid_o),
    .out_ready_i        (out_ready_i),
    .shut_off_o         (shut_off_o),
    .error_latched_o    (error_latched_o),
    .new_error_o        (new_error_o),
    .current_level_o    (current_level_o),
    .load_fraction_o    (load_fraction_o),
    .reference_level_o  (reference_level_o),
    .calibration_done_o (calibration_done_o)
  );

  always #5 clk_i = ~clk_i;

  // Watchdog: a hung handshake ends the run as a failure.
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  // The receiver stalls in bursts of random length while idling is
  // enabled, and otherwise takes every result as soon as it is offered.
  always @(posedge clk_i) begin
    if (stall_left != 0) begin
      stall_left  <= stall_left - 1;
      out_ready_i <= 1'b0;
    end else if (idle_en && $urandom_range(0, 4) == 0) begin
      stall_left  <= $urandom_range(0, 3);
      out_ready_i <= 1'b0;
    end else begin
      out_ready_i <= 1'b1;
    end
  end

  // Every result transfer is checked against the oldest expectation. The
  // outputs are read right after the edge, so they hold the values that the
  // edge itself saw.
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready_i) begin
      seen.shut_off         = shut_off_o;
      seen.error_latched    = error_latched_o;
      seen.new_error        = new_error_o;
      seen.current_level    = current_level_o;
      seen.load_fraction    = load_fraction_o;
      seen.reference_level  = reference_level_o;
      seen.calibration_done = calibration_done_o;
      board.compare_result(seen);
    end
  end

  function automatic logic [ADC_W-1:0] clamp_adc(input int v);
    if (v < 0) return '0;
    if (v > 1023) return ADC_W'(1023);
    return ADC_W'(v);
  endfunction

  // Tick samples lean towards the interesting regions: both rails, the zero
  // reference itself (so the difference changes sign) and the trip level.
  function automatic logic [ADC_W-1:0] pick_tick_sample();
    int centre;
    centre = int'(board.zero_ref[LEVEL_W-1:FRAC_BITS]);
    case ($urandom_range(0, 4))
      0:       return ADC_W'($urandom_range(0, 1023));
      1:       return ADC_W'($urandom_range(900, 1023));
      2:       return ADC_W'($urandom_range(0, 60));
      3:       return clamp_adc(centre + int'($urandom_range(0, 40)) - 20);
      default: return clamp_adc(centre + int'(board.limit) + int'($urandom_range(0, 60)) - 30);
    endcase
  endfunction

  // Offers one item and waits for its transfer. Valid is only lowered for an
  // idle gap, so a back-to-back item keeps it high without a glitch.
  task automatic send_item(input otm_func_e f, input logic [ADC_W-1:0] s, input logic fl);
    if (idle_en && $urandom_range(0, 3) == 0) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk_i);
    end
    in_valid_i   <= 1'b1;
    func_i       <= f;
    adc_sample_i <= s;
    fault_low_i  <= fl;
    do @(posedge clk_i); while (!in_ready_o);
    board.accept_item(f, s, fl);
    items_sent++;
  endtask

  // Withdraws the input and waits until every expected result has been seen,
  // which leaves the unit idle since each item gives exactly one result.
  task automatic drain_results();
    in_valid_i <= 1'b0;
    while (board.pending() != 0) @(posedge clk_i);
  endtask

  // Writes all four registers back to back once the unit has gone idle.
  task automatic apply_settings(input logic [CFG_DATA_W-1:0] alpha_v,
                                input logic [CFG_DATA_W-1:0] limit_v,
                                input logic [CFG_DATA_W-1:0] period_v,
                                input logic [CFG_DATA_W-1:0] sym_v);
    otm_cfg_e              reg_order [4];
    logic [CFG_DATA_W-1:0] value [4];
    reg_order = '{CFG_ALPHA, CFG_LIMIT, CFG_PERIOD, CFG_SYMMETRIC};
    value     = '{alpha_v, limit_v, period_v, sym_v};
    drain_results();
    for (int i = 0; i < 4; i++) begin
      cfg_valid_i <= 1'b1;
      cfg_index_i <= reg_order[i];
      cfg_data_i  <= value[i];
      do @(posedge clk_i); while (!cfg_ready_o);
      board.write_reg(reg_order[i], value[i]);
    end
    cfg_valid_i <= 1'b0;
  endtask

  // Picks a fresh setting for a phase. Limit data carries random upper bits,
  // which the unit must drop; some patterns leave a limit of zero.
  task automatic randomise_settings();
    logic [CFG_DATA_W-1:0] alpha_v;
    logic [CFG_DATA_W-1:0] limit_v;
    logic [CFG_DATA_W-1:0] period_v;
    case ($urandom_range(0, 4))
      0:       alpha_v = '0;
      1:       alpha_v = '1;
      2:       alpha_v = ALPHA_RST;
      3:       alpha_v = 16'($urandom_range(20000, 65535));
      default: alpha_v = 16'($urandom_range(0, 65535));
    endcase
    case ($urandom_range(0, 7))
      0:       limit_v = 16'd1;
      1:       limit_v = {6'($urandom_range(0, 63)), 10'h3FF};
      2:       limit_v = {6'($urandom_range(0, 63)), 10'h000};
      3, 4:    limit_v = 16'($urandom_range(1, 40));
      default: limit_v = 16'($urandom_range(0, 65535));
    endcase
    case ($urandom_range(0, 15))
      0:          period_v = '1;
      1, 2:       period_v = 16'($urandom_range(5, 30));
      3, 4, 5, 6: period_v = '0;
      7, 8, 9:    period_v = 16'd1;
      default:    period_v = 16'($urandom_range(2, 4));
    endcase
    apply_settings(alpha_v, limit_v, period_v, 16'($urandom_range(0, 65535)));
  endtask

  // A calibration run: a start followed by readings scattered around one
  // level, with ticks mixed in so that smoothing continues on the old
  // reference. A count below the full run leaves a broken sequence behind.
  task automatic run_calibration(input int count);
    int centre;
    int spread;
    centre = int'($urandom_range(0, 1023));
    spread = int'($urandom_range(0, 12));
    send_item(FUNC_CAL_START, ADC_W'($urandom_range(0, 1023)), 1'($urandom_range(0, 1)));
    for (int n = 0; n < count; n++) begin
      if ($urandom_range(0, 4) == 0) begin
        send_item(FUNC_TICK, pick_tick_sample(), $urandom_range(0, 9) == 0);
      end
      send_item(FUNC_CAL_SAMPLE, clamp_adc(centre + int'($urandom_range(0, 2 * spread)) - spread),
                1'($urandom_range(0, 1)));
    end
  endtask

  // Mostly bursts of ticks, with occasional clears, calibration runs and
  // stray calibration items as noise.
  task automatic random_action();
    int pick;
    pick = $urandom_range(0, 99);
    if (pick < 3 && board.symmetric) begin
      run_calibration(($urandom_range(0, 3) != 0) ? CAL_SAMPLES : $urandom_range(1, 99));
    end else if (pick < 10) begin
      send_item(FUNC_CLEAR, ADC_W'($urandom_range(0, 1023)), 1'($urandom_range(0, 1)));
    end else if (pick < 13) begin
      send_item(FUNC_CAL_SAMPLE, ADC_W'($urandom_range(0, 1023)), 1'($urandom_range(0, 1)));
    end else if (pick < 15) begin
      send_item(FUNC_CAL_START, ADC_W'($urandom_range(0, 1023)), 1'($urandom_range(0, 1)));
    end else begin
      repeat ($urandom_range(1, 8)) begin
        send_item(FUNC_TICK, pick_tick_sample(), $urandom_range(0, 9) == 0);
      end
    end
  endtask

  initial begin
    int phase_end;
    board = new();
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed part at the reset setting: both sample rails, a fault that
    // latches the error, a second trip while it is latched, a clear, a
    // calibration reading that is ignored because the reference is valid,
    // and a calibration start on an asymmetric sensor.
    send_item(FUNC_TICK, ADC_W'(0), 1'b0);
    send_item(FUNC_TICK, ADC_W'(1023), 1'b0);
    send_item(FUNC_TICK, ADC_W'(1023), 1'b1);
    send_item(FUNC_TICK, ADC_W'(0), 1'b1);
    send_item(FUNC_CLEAR, ADC_W'(0), 1'b0);
    send_item(FUNC_CAL_SAMPLE, ADC_W'(1023), 1'b1);
    send_item(FUNC_CAL_START, ADC_W'(0), 1'b0);

    // Almost all weight on the new sample, the lowest nonzero limit and a zero period, so
    // that every tick updates and a single full-scale reading saturates.
    apply_settings('1, 16'd1, '0, '0);
    send_item(FUNC_TICK, ADC_W'(1023), 1'b0);
    send_item(FUNC_TICK, ADC_W'(0), 1'b0);
    send_item(FUNC_CLEAR, ADC_W'(1023), 1'b1);

    // Zero weight freezes the smoothed value; all-ones data must give the
    // highest limit and a symmetric sensor. A calibration is started and
    // left incomplete while ticks still run on the old reference.
    apply_settings('0, '1, 16'd2, '1);
    send_item(FUNC_CAL_START, ADC_W'(0), 1'b0);
    send_item(FUNC_TICK, ADC_W'(1023), 1'b0);
    send_item(FUNC_TICK, ADC_W'(1023), 1'b0);
    send_item(FUNC_CAL_SAMPLE, ADC_W'(1023), 1'b0);
    send_item(FUNC_CAL_SAMPLE, ADC_W'(0), 1'b1);
    send_item(FUNC_CAL_SAMPLE, ADC_W'(512), 1'b0);
    send_item(FUNC_CLEAR, ADC_W'(0), 1'b0);

    // A limit that reads as zero: the load saturates and any nonzero
    // smoothed value trips. The closing calibration start on an asymmetric
    // sensor must restore a valid zero reference mid-calibration.
    apply_settings(16'h8000, 16'h0400, 16'd1, '0);
    send_item(FUNC_TICK, ADC_W'(0), 1'b0);
    send_item(FUNC_TICK, ADC_W'(0), 1'b0);
    send_item(FUNC_CAL_START, ADC_W'(1023), 1'b0);

    // Random phases, each with its own setting. One middle phase and the
    // final one run without any idling on either side.
    for (int p = 0; p < PHASES; p++) begin
      idle_en = (p != 4) && (p != PHASES - 1);
      randomise_settings();
      phase_end = items_sent + PHASE_ITEMS;
      if (board.symmetric && $urandom_range(0, 1) == 1) run_calibration(CAL_SAMPLES);
      while (items_sent < phase_end) random_action();
    end

    drain_results();
    repeat (SETTLE_CYCLES) @(posedge clk_i);
    if (board.mismatches == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule

// File: sim.f
design/otm_pkg.sv
design/otm_mult.sv
design/otm_div.sv
design/overcurrent_trip_monitor_unit.sv
tb/sv/otm_tb_pkg.sv
tb/sv/overcurrent_trip_monitor_unit_test.sv
